@@ src/egp_pkg.sv @@
package egp_pkg;

  localparam int unsigned NumCpusDefault   = 8;
  localparam int unsigned QueueDepthDefault = 16;

  localparam int unsigned FnWidth    = 64;
  localparam int unsigned ArgWidth   = 64;
  localparam int unsigned EpochWidth = 32;
  localparam int unsigned DepthWidth = 16;
  localparam int unsigned OnlineWidth = 4;

  localparam logic [DepthWidth-1:0] DepthMax = '1;
  localparam logic [EpochWidth-1:0] EpochReset = EpochWidth'(1);
  localparam logic [OnlineWidth-1:0] OnlineReset = OnlineWidth'(1);

  // request codes
  localparam logic [2:0] ReqEnter   = 3'd0;
  localparam logic [2:0] ReqLeave   = 3'd1;
  localparam logic [2:0] ReqEnqueue = 3'd2;
  localparam logic [2:0] ReqTick    = 3'd3;
  localparam logic [2:0] ReqIdle    = 3'd4;
  localparam logic [2:0] ReqPoll    = 3'd5;

  // status codes
  localparam logic [1:0] StOk       = 2'd0;
  localparam logic [1:0] StRefused  = 2'd1;
  localparam logic [1:0] StCpuIgn   = 2'd2;
  localparam logic [1:0] StNotQuiet = 2'd3;

  typedef struct packed {
    logic [FnWidth-1:0]  fn;
    logic [ArgWidth-1:0] arg;
  } entry_t;

endpackage

@@ src/egp_queue.sv @@
module egp_queue #(
  parameter int unsigned QueueDepth = egp_pkg::QueueDepthDefault,
  localparam int unsigned AW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1
) (
  input  logic           clk_i,
  input  logic           wr_en_i,
  input  logic [AW-1:0]  wr_addr_i,
  input  egp_pkg::entry_t wr_data_i,
  input  logic           rd_en_i,
  input  logic [AW-1:0]  rd_addr_i,
  output egp_pkg::entry_t rd_data_o
);
  import egp_pkg::*;

  entry_t mem_q [QueueDepth];
  entry_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

@@ src/epoch_grace_period_tracker.sv @@
// Grace period tracker: read enter/leave, enqueue, tick, idle and unknown requests each
// give one result; a poll scans one CPU mark a cycle and, if every online mark is current,
// walks the callback queue one entry at a time through its read and write ports.
// One item at a time: the input is ready only when idle and the result register is free.
// Reset (async, active low) sets epoch 1, online_cpus 1, clears marks, depths and counts;
// queue contents are left undefined and never read before they are written.
module epoch_grace_period_tracker #(
  parameter int unsigned NumCpus    = egp_pkg::NumCpusDefault,
  parameter int unsigned QueueDepth = egp_pkg::QueueDepthDefault,
  localparam int unsigned CW = $clog2(QueueDepth + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [egp_pkg::OnlineWidth-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [2:0]                      req_type_i,
  input  logic [7:0]                      cpu_index_i,
  input  logic [egp_pkg::FnWidth-1:0]     callback_fn_i,
  input  logic [egp_pkg::ArgWidth-1:0]    callback_arg_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [1:0]                      status_o,
  output logic                            released_valid_o,
  output logic [egp_pkg::FnWidth-1:0]     released_fn_o,
  output logic [egp_pkg::ArgWidth-1:0]    released_arg_o,
  output logic                            epoch_advanced_o,
  output logic                            last_o,
  output logic [egp_pkg::EpochWidth-1:0]  current_epoch_o,
  output logic [CW-1:0]                   queued_count_o,
  output logic [egp_pkg::EpochWidth-1:0]  completed_count_o
);
  import egp_pkg::*;

  localparam int unsigned AW   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CPUW = (NumCpus > 1) ? $clog2(NumCpus) : 1;
  localparam int unsigned SW   = $clog2(NumCpus + 1);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_CHECK = 6'b000010,
    S_NOTQ  = 6'b000100,
    S_RD    = 6'b001000,
    S_USE   = 6'b010000,
    S_CLOSE = 6'b100000
  } state_e;

  typedef struct packed {
    logic [1:0]          status;
    logic                rel_valid;
    logic [FnWidth-1:0]  fn;
    logic [ArgWidth-1:0] arg;
    logic                adv;
    logic                last;
    logic [EpochWidth-1:0] epoch;
    logic [CW-1:0]       queued;
    logic [EpochWidth-1:0] total;
  } result_t;

  state_e state_q, state_d;
  logic [OnlineWidth-1:0] online_q;
  logic [EpochWidth-1:0]  epoch_q, epoch_d;
  logic [EpochWidth-1:0]  total_q, total_d;
  logic [CW-1:0]          count_q, count_d;
  // entries stamped with the current epoch always form the tail of the queue
  logic [CW-1:0]          fresh_q, fresh_d;
  logic [CW-1:0]          rel_q, rel_d;
  logic [CW-1:0]          cnt_q, cnt_d;
  logic [CW-1:0]          idx_q, idx_d;
  logic [SW-1:0]          scan_q, scan_d;
  logic [EpochWidth-1:0]  mark_q  [NumCpus];
  logic [DepthWidth-1:0]  depth_q [NumCpus];

  logic                   out_valid_q;
  result_t                out_q, out_d;
  logic                   out_load, out_free;

  logic                   depth_we, mark_we;
  logic [DepthWidth-1:0]  depth_wdata;
  logic [CPUW-1:0]        cpu_sel;
  logic                   cpu_ok;
  logic [SW-1:0]          scan_lim;

  logic                   q_we, q_re;
  logic [AW-1:0]          q_waddr;
  entry_t                 q_wdata, q_rdata;

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE) && out_free;

  assign cpu_sel  = cpu_index_i[CPUW-1:0];
  assign cpu_ok   = (32'(cpu_index_i) < NumCpus) && (32'(cpu_index_i) < 32'(online_q));
  assign scan_lim = (32'(online_q) < NumCpus) ? SW'(online_q) : SW'(NumCpus);

  egp_queue #(.QueueDepth(QueueDepth)) u_queue (
    .clk_i     (clk_i),
    .wr_en_i   (q_we),
    .wr_addr_i (q_waddr),
    .wr_data_i (q_wdata),
    .rd_en_i   (q_re),
    .rd_addr_i (idx_q[AW-1:0]),
    .rd_data_o (q_rdata)
  );

  always_comb begin
    state_d     = state_q;
    epoch_d     = epoch_q;
    total_d     = total_q;
    count_d     = count_q;
    fresh_d     = fresh_q;
    rel_d       = rel_q;
    cnt_d       = cnt_q;
    idx_d       = idx_q;
    scan_d      = scan_q;
    depth_we    = 1'b0;
    mark_we     = 1'b0;
    depth_wdata = depth_q[cpu_sel];
    q_we        = 1'b0;
    q_re        = 1'b0;
    q_waddr     = count_q[AW-1:0];
    q_wdata     = '{fn: callback_fn_i, arg: callback_arg_i};
    out_load    = 1'b0;
    out_d       = '0;
    out_d.last  = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          out_load = 1'b1;
          unique case (req_type_i)
            ReqEnter, ReqLeave, ReqTick, ReqIdle: begin
              if (!cpu_ok) begin
                out_d.status = StCpuIgn;
              end else begin
                unique case (req_type_i)
                  ReqEnter: begin
                    depth_we = 1'b1;
                    if (depth_q[cpu_sel] != DepthMax) begin
                      depth_wdata = depth_q[cpu_sel] + DepthWidth'(1);
                    end
                  end
                  ReqLeave: begin
                    depth_we = 1'b1;
                    if (depth_q[cpu_sel] != '0) begin
                      depth_wdata = depth_q[cpu_sel] - DepthWidth'(1);
                    end
                  end
                  ReqTick: mark_we = (depth_q[cpu_sel] == '0);
                  default: mark_we = 1'b1;
                endcase
              end
            end
            ReqEnqueue: begin
              if (callback_fn_i == '0 || 32'(count_q) >= QueueDepth) begin
                out_d.status = StRefused;
              end else begin
                q_we    = 1'b1;
                count_d = count_q + CW'(1);
                fresh_d = fresh_q + CW'(1);
              end
            end
            ReqPoll: begin
              // hold the result until the mark scan decides
              out_load = 1'b0;
              scan_d   = '0;
              state_d  = S_CHECK;
            end
            default: ;
          endcase
        end
      end
      S_CHECK: begin
        if (scan_q == scan_lim) begin
          // grace period closed: settle the final counts before any result leaves
          rel_d   = count_q - fresh_q;
          cnt_d   = count_q;
          idx_d   = '0;
          count_d = fresh_q;
          fresh_d = '0;
          epoch_d = epoch_q + EpochWidth'(1);
          total_d = total_q + EpochWidth'(count_q - fresh_q);
          state_d = (count_q == fresh_q) ? S_CLOSE : S_RD;
        end else if (mark_q[scan_q[CPUW-1:0]] != epoch_q) begin
          state_d = S_NOTQ;
        end else begin
          scan_d = scan_q + SW'(1);
        end
      end
      S_NOTQ: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_d.status = StNotQuiet;
          state_d      = S_IDLE;
        end
      end
      S_RD: begin
        q_re    = 1'b1;
        state_d = S_USE;
      end
      S_USE: begin
        if (idx_q < rel_q) begin
          if (out_free) begin
            out_load        = 1'b1;
            out_d.rel_valid = 1'b1;
            out_d.fn        = q_rdata.fn;
            out_d.arg       = q_rdata.arg;
            out_d.last      = 1'b0;
            idx_d           = idx_q + CW'(1);
            state_d         = (idx_q + CW'(1) == cnt_q) ? S_CLOSE : S_RD;
          end
        end else begin
          // shift a survivor down to the head
          q_we    = 1'b1;
          q_waddr = AW'(idx_q - rel_q);
          q_wdata = q_rdata;
          idx_d   = idx_q + CW'(1);
          state_d = (idx_q + CW'(1) == cnt_q) ? S_CLOSE : S_RD;
        end
      end
      S_CLOSE: begin
        if (out_free) begin
          out_load  = 1'b1;
          out_d.adv = 1'b1;
          state_d   = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase

    out_d.epoch  = epoch_q;
    out_d.queued = count_d;
    out_d.total  = total_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      online_q <= OnlineReset;
      epoch_q  <= EpochReset;
      total_q  <= '0;
      count_q  <= '0;
      fresh_q  <= '0;
      rel_q    <= '0;
      cnt_q    <= '0;
      idx_q    <= '0;
      scan_q   <= '0;
      for (int i = 0; i < NumCpus; i++) begin
        mark_q[i]  <= '0;
        depth_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (cfg_valid_i && cfg_ready_o) begin
        online_q <= cfg_data_i;
      end
      epoch_q <= epoch_d;
      total_q <= total_d;
      count_q <= count_d;
      fresh_q <= fresh_d;
      rel_q   <= rel_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
      scan_q  <= scan_d;
      if (depth_we) begin
        depth_q[cpu_sel] <= depth_wdata;
      end
      if (mark_we) begin
        mark_q[cpu_sel] <= epoch_q;
      end
    end
  end

  // result register: drop on transfer, load when free
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign status_o          = out_q.status;
  assign released_valid_o  = out_q.rel_valid;
  assign released_fn_o     = out_q.fn;
  assign released_arg_o    = out_q.arg;
  assign epoch_advanced_o  = out_q.adv;
  assign last_o            = out_q.last;
  assign current_epoch_o   = out_q.epoch;
  assign queued_count_o    = out_q.queued;
  assign completed_count_o = out_q.total;

endmodule

@@ verif/testbench.sv @@
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import egp_pkg::*;

  localparam int unsigned NCPU  = NumCpusDefault;
  localparam int unsigned QDEP  = QueueDepthDefault;
  localparam int unsigned CW    = $clog2(QDEP + 1);
  // Worst poll: a full mark scan plus a read and a use step per queue entry.
  localparam int unsigned DRAIN = 4 * (NCPU + 1 + 2 * QDEP) + 20;

  // One result as the block reports it.
  typedef struct packed {
    logic [1:0]            status;
    logic                  rel_valid;
    logic [FnWidth-1:0]    rel_fn;
    logic [ArgWidth-1:0]   rel_arg;
    logic                  advanced;
    logic                  last;
    logic [EpochWidth-1:0] epoch;
    logic [CW-1:0]         queued;
    logic [EpochWidth-1:0] completed;
  } grace_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                   cfg_valid_i = 1'b0;
  logic                   cfg_ready_o;
  logic [OnlineWidth-1:0] cfg_data_i = '0;
  logic                   in_valid_i = 1'b0;
  logic                   in_ready_o;
  logic [2:0]             req_type_i = '0;
  logic [7:0]             cpu_index_i = '0;
  logic [FnWidth-1:0]     callback_fn_i = '0;
  logic [ArgWidth-1:0]    callback_arg_i = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  logic [1:0]             status_o;
  logic                   released_valid_o;
  logic [FnWidth-1:0]     released_fn_o;
  logic [ArgWidth-1:0]    released_arg_o;
  logic                   epoch_advanced_o;
  logic                   last_o;
  logic [EpochWidth-1:0]  current_epoch_o;
  logic [CW-1:0]          queued_count_o;
  logic [EpochWidth-1:0]  completed_count_o;

  epoch_grace_period_tracker DUT (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_ready_o, .req_type_i, .cpu_index_i, .callback_fn_i, .callback_arg_i,
    .out_valid_o, .out_ready_i, .status_o, .released_valid_o, .released_fn_o,
    .released_arg_o, .epoch_advanced_o, .last_o, .current_epoch_o, .queued_count_o,
    .completed_count_o
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow copy of the tracker state.
  logic [OnlineWidth-1:0] sh_online;
  logic [EpochWidth-1:0]  sh_epoch;
  logic [EpochWidth-1:0]  sh_mark  [NCPU];
  logic [DepthWidth-1:0]  sh_depth [NCPU];
  logic [FnWidth-1:0]     sh_fn    [QDEP];
  logic [ArgWidth-1:0]    sh_arg   [QDEP];
  logic [EpochWidth-1:0]  sh_stamp [QDEP];
  int unsigned            sh_count;
  logic [EpochWidth-1:0]  sh_total;

  grace_result_t pending_results[$];
  int unsigned   mismatches = 0;

  // Work out the results of one accepted event and queue them.
  task automatic predict_event(input logic [2:0] rt, input logic [7:0] cpu,
                               input logic [FnWidth-1:0] fn, input logic [ArgWidth-1:0] arg);
    grace_result_t batch[$];
    grace_result_t r;
    bit cpu_valid;
    bit quiet;
    int unsigned keep;
    r = '0;
    r.last = 1'b1;
    cpu_valid = (cpu < NCPU) && (cpu < sh_online);
    case (rt)
      ReqEnter, ReqLeave, ReqTick, ReqIdle: begin
        if (!cpu_valid) begin
          r.status = StCpuIgn;
        end else if (rt == ReqEnter) begin
          if (sh_depth[cpu] != DepthMax) sh_depth[cpu]++;
        end else if (rt == ReqLeave) begin
          if (sh_depth[cpu] != 0) sh_depth[cpu]--;
        end else if (rt == ReqTick) begin
          if (sh_depth[cpu] == 0) sh_mark[cpu] = sh_epoch;
        end else begin
          sh_mark[cpu] = sh_epoch;
        end
        batch.push_back(r);
      end
      ReqEnqueue: begin
        if (fn == 0 || sh_count >= QDEP) begin
          r.status = StRefused;
        end else begin
          sh_fn[sh_count] = fn;
          sh_arg[sh_count] = arg;
          sh_stamp[sh_count] = sh_epoch;
          sh_count++;
        end
        batch.push_back(r);
      end
      ReqPoll: begin
        quiet = 1'b1;
        for (int c = 0; c < NCPU && c < sh_online; c++)
          if (sh_mark[c] != sh_epoch) quiet = 1'b0;
        if (!quiet) begin
          r.status = StNotQuiet;
          batch.push_back(r);
        end else begin
          keep = 0;
          for (int i = 0; i < sh_count; i++) begin
            if (sh_stamp[i] != sh_epoch) begin
              r = '0;
              r.status = StOk;
              r.rel_valid = 1'b1;
              r.rel_fn = sh_fn[i];
              r.rel_arg = sh_arg[i];
              batch.push_back(r);
              sh_total++;
            end else begin
              sh_fn[keep] = sh_fn[i];
              sh_arg[keep] = sh_arg[i];
              sh_stamp[keep] = sh_stamp[i];
              keep++;
            end
          end
          sh_count = keep;
          sh_epoch++;
          r = '0;
          r.advanced = 1'b1;
          r.last = 1'b1;
          batch.push_back(r);
        end
      end
      default: batch.push_back(r); // unknown request: no effect
    endcase
    // Every result of an event carries the state after the whole event.
    foreach (batch[k]) begin
      batch[k].epoch = sh_epoch;
      batch[k].queued = CW'(sh_count);
      batch[k].completed = sh_total;
      pending_results.push_back(batch[k]);
    end
  endtask

  // Random gap: mostly none or short, now and then long.
  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 50) return 0;
    if (roll < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Offer one event, hold it until the transfer, then drop valid for a random gap, if any.
  task automatic send_event(input logic [2:0] rt, input logic [7:0] cpu,
                            input logic [FnWidth-1:0] fn, input logic [ArgWidth-1:0] arg,
                            input bit gaps = 1'b1);
    int unsigned gap;
    in_valid_i     <= 1'b1;
    req_type_i     <= rt;
    cpu_index_i    <= cpu;
    callback_fn_i  <= fn;
    callback_arg_i <= arg;
    do @(posedge clk_i); while (!in_ready_o);
    predict_event(rt, cpu, fn, arg);
    gap = gaps ? pick_gap() : 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Drop valid and wait for every result, then for the block to settle.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic set_online(input logic [OnlineWidth-1:0] n);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= n;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sh_online = n;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Mark every online CPU quiet, then poll.
  task automatic close_period();
    for (int c = 0; c < NCPU && c < sh_online; c++)
      send_event(ReqIdle, 8'(c), rand64(), rand64());
    send_event(ReqPoll, 8'($urandom), rand64(), rand64());
  endtask

  // Result side: stretches of steady ready, random stalls, a few long holds.
  int unsigned ready_left = 0;
  always @(posedge clk_i) begin
    if (ready_left == 0) begin
      case ($urandom_range(9))
        0, 1, 2: begin out_ready_i <= 1'b1; ready_left <= $urandom_range(40, 5); end
        3:       begin out_ready_i <= 1'b0; ready_left <= $urandom_range(30, 8); end
        default: begin out_ready_i <= 1'($urandom_range(1)); ready_left <= 1; end
      endcase
    end else begin
      ready_left <= ready_left - 1;
    end
  end

  // Compare each result transfer against the oldest expectation.
  always @(posedge clk_i) begin
    grace_result_t got;
    grace_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{status_o, released_valid_o, released_fn_o, released_arg_o, epoch_advanced_o,
              last_o, current_epoch_o, queued_count_o, completed_count_o};
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: status %0d/%0d rel %0b/%0b fn %h/%h arg %h/%h",
                     want.status, got.status, want.rel_valid, got.rel_valid,
                     want.rel_fn, got.rel_fn, want.rel_arg, got.rel_arg);
            $display("  adv %0b/%0b last %0b/%0b epoch %0d/%0d queued %0d/%0d done %0d/%0d",
                     want.advanced, got.advanced, want.last, got.last, want.epoch, got.epoch,
                     want.queued, got.queued, want.completed, got.completed);
          end
        end
      end
    end
  end

  // Fresh state: poll not quiet, unknown requests, invalid CPUs.
  task automatic test_reset_state();
    send_event(ReqPoll, 8'd0, '0, '0);
    send_event(3'd6, 8'hFF, '1, '1);
    send_event(3'd7, 8'h00, '0, '0);
    send_event(ReqEnter, 8'd1, '0, '0);
    send_event(ReqTick, 8'hFF, '0, '0);
    send_event(ReqIdle, 8'd200, '0, '0);
  endtask

  // Tick inside a section makes no mark; leave at depth zero stays zero.
  task automatic test_read_sections();
    send_event(ReqEnter, 8'd0, '0, '0);
    send_event(ReqTick, 8'd0, '0, '0);
    send_event(ReqPoll, 8'd0, '0, '0);
    send_event(ReqLeave, 8'd0, '0, '0);
    send_event(ReqLeave, 8'd0, '0, '0);
    send_event(ReqTick, 8'd0, '0, '0);
    send_event(ReqPoll, 8'd0, '0, '0);
  endtask

  // Null handle refused, fill to full, then release over two grace periods.
  task automatic test_enqueue();
    send_event(ReqEnqueue, 8'hAA, '0, '1);
    send_event(ReqEnqueue, 8'h55, '1, '1);
    for (int i = 1; i < QDEP; i++) send_event(ReqEnqueue, 8'($urandom), rand64(), rand64());
    send_event(ReqEnqueue, 8'd0, rand64(), rand64());
    // Hold off the sender until the queue contents are confirmed.
    wait_idle();
    close_period();
    close_period();
  endtask

  // Online count at the extremes: none, all, and above the CPU count.
  task automatic test_online_extremes();
    set_online(4'd0);
    send_event(ReqIdle, 8'd0, '0, '0);
    send_event(ReqEnqueue, 8'd0, rand64(), rand64());
    send_event(ReqPoll, 8'd0, '0, '0);
    send_event(ReqPoll, 8'd0, '0, '0);
    set_online(4'd8);
    send_event(ReqIdle, 8'd7, '0, '0);
    send_event(ReqPoll, 8'd0, '0, '0);
    close_period();
    set_online(4'd15);
    send_event(ReqIdle, 8'd8, '0, '0);
    send_event(ReqTick, 8'd14, '0, '0);
    close_period();
  endtask

  // Nest sections on one CPU back to back, then unwind past zero.
  task automatic test_nesting();
    for (int i = 0; i < 3; i++) send_event(ReqEnter, 8'd7, '0, '0, 1'b0);
    send_event(ReqTick, 8'd7, '0, '0);
    for (int i = 0; i < 4; i++) send_event(ReqLeave, 8'd7, '0, '0, 1'b0);
    send_event(ReqTick, 8'd7, '0, '0);
    send_event(ReqPoll, 8'd0, '0, '0);
  endtask

  // Mostly well-formed traffic: enqueues, sections, quiescence and polls.
  task automatic test_random_traffic();
    logic [7:0] cpu;
    for (int n = 0; n < 30; n++) begin
      if (n == 10) set_online(4'd2);
      if (n == 20) set_online(4'd3);
      cpu = ($urandom_range(9) == 0) ? 8'($urandom) : 8'($urandom_range(NCPU - 1));
      case ($urandom_range(19))
        0, 1, 2, 3, 4: send_event(ReqEnqueue, cpu,
                                  ($urandom_range(15) == 0) ? '0 : rand64(), rand64());
        5, 6:          send_event(ReqEnter, cpu, rand64(), rand64());
        7, 8:          send_event(ReqLeave, cpu, rand64(), rand64());
        9, 10:         send_event(ReqTick, cpu, rand64(), rand64());
        11:            send_event(ReqIdle, cpu, rand64(), rand64());
        12:            send_event(ReqPoll, cpu, rand64(), rand64());
        13:            send_event(3'($urandom_range(7)), cpu, rand64(), rand64());
        default:       close_period();
      endcase
    end
  endtask

  initial begin
    sh_online = OnlineReset;
    sh_epoch  = EpochReset;
    sh_count  = 0;
    sh_total  = '0;
    foreach (sh_mark[c]) begin
      sh_mark[c]  = '0;
      sh_depth[c] = '0;
    end
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_state();
    test_read_sections();
    test_enqueue();
    test_online_extremes();
    test_nesting();
    set_online(4'd1);
    test_random_traffic();

    wait_idle();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("** epoch_grace_period_tracker: PASSED **");
    end else begin
      $display("** epoch_grace_period_tracker: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("** epoch_grace_period_tracker: FAILED **");
    $finish;
  end

endmodule

@@ epoch_grace_period_tracker.f @@
src/egp_pkg.sv
src/egp_queue.sv
src/epoch_grace_period_tracker.sv
verif/testbench.sv
